/* rtl/dwr_pkg.sv */
`default_nettype none
package dwr_pkg;

  // Field and register widths
  localparam int COL_W    = 9;
  localparam int COUNT_W  = 13;
  localparam int IDX_W    = 12;
  localparam int PROD_W   = COL_W + COUNT_W;
  localparam int WIDTH_W  = 9;
  localparam int HEIGHT_W = 8;
  localparam int TOP_W    = 8;
  localparam int LEFT_W   = 9;
  localparam int COLOR_W  = 16;
  localparam int X_W      = 10;
  localparam int Y_W      = 9;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int CNT_W    = 5;

  localparam int SAMPLE_DEPTH = 4096;

  // Command codes
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_DRAW = 1'b1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_X       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TOP_Y        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_AREA_WIDTH   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_AREA_HEIGHT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_COLOR   = 3'd5;

  // Reset values
  localparam logic [COUNT_W-1:0]  RST_SAMPLE_COUNT = 13'd0;
  localparam logic [LEFT_W-1:0]   RST_LEFT_X       = 9'd32;
  localparam logic [TOP_W-1:0]    RST_TOP_Y        = 8'd15;
  localparam logic [WIDTH_W-1:0]  RST_AREA_WIDTH   = 9'd288;
  localparam logic [HEIGHT_W-1:0] RST_AREA_HEIGHT  = 8'd218;
  localparam logic [COLOR_W-1:0]  RST_LINE_COLOR   = 16'd0;

  // Multiply/divide sequencer phases
  typedef enum logic [1:0] {
    MD_IDLE,
    MD_MUL,
    MD_DIV
  } md_state_t;

  // Top-level control states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_READ,
    ST_EDGE,
    ST_POINT
  } dwr_state_t;

endpackage
`default_nettype wire

/* rtl/digital_waveform_rasterizer_top.sv */
`default_nettype none
// One-bit waveform rasterizer. A load item (cmd 0) writes one bit into the
// 4096-entry sample store. A draw item (cmd 1) with nonzero area width and
// height maps its column to a sample with a bit-serial shift-add multiply and
// a restoring divide by area_width, reads the store, and emits an edge
// segment when the level changed after column 0, then the level point flagged
// last; a draw with zero area width or height is accepted and dropped. A draw
// goes through a start state, the multiply/divide steps of the
// one-bit-per-cycle multiply/divide unit, a store read, the edge slot and the
// point, waiting on output stalls at the edge and the point; no new item is
// accepted until it is done. A draw with sample_count zero skips the divider
// and the store read and registers the low point. Store entries must be
// loaded before any draw reads them.
module digital_waveform_rasterizer_top (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_write,
  input  wire logic [dwr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [dwr_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic                           cmd,
  input  wire logic [dwr_pkg::IDX_W-1:0]      sample_index,
  input  wire logic                           sample_bit,
  input  wire logic [dwr_pkg::COL_W-1:0]      column,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [dwr_pkg::X_W-1:0]             seg_x,
  output logic [dwr_pkg::Y_W-1:0]             seg_y_from,
  output logic [dwr_pkg::Y_W-1:0]             seg_y_to,
  output logic [dwr_pkg::COLOR_W-1:0]         seg_color,
  output logic                                is_edge,
  output logic                                last
);

  // Configuration registers
  logic [dwr_pkg::COUNT_W-1:0]  sample_count;
  logic [dwr_pkg::LEFT_W-1:0]   left_x;
  logic [dwr_pkg::TOP_W-1:0]    top_y;
  logic [dwr_pkg::WIDTH_W-1:0]  area_width;
  logic [dwr_pkg::HEIGHT_W-1:0] area_height;
  logic [dwr_pkg::COLOR_W-1:0]  line_color;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= dwr_pkg::RST_SAMPLE_COUNT;
      left_x       <= dwr_pkg::RST_LEFT_X;
      top_y        <= dwr_pkg::RST_TOP_Y;
      area_width   <= dwr_pkg::RST_AREA_WIDTH;
      area_height  <= dwr_pkg::RST_AREA_HEIGHT;
      line_color   <= dwr_pkg::RST_LINE_COLOR;
    end else if (cfg_write) begin
      case (cfg_index)
        dwr_pkg::REG_SAMPLE_COUNT: sample_count <= cfg_data[dwr_pkg::COUNT_W-1:0];
        dwr_pkg::REG_LEFT_X:       left_x       <= cfg_data[dwr_pkg::LEFT_W-1:0];
        dwr_pkg::REG_TOP_Y:        top_y        <= cfg_data[dwr_pkg::TOP_W-1:0];
        dwr_pkg::REG_AREA_WIDTH:   area_width   <= cfg_data[dwr_pkg::WIDTH_W-1:0];
        dwr_pkg::REG_AREA_HEIGHT:  area_height  <= cfg_data[dwr_pkg::HEIGHT_W-1:0];
        dwr_pkg::REG_LINE_COLOR:   line_color   <= cfg_data[dwr_pkg::COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  // Level rows from lane geometry
  logic [dwr_pkg::HEIGHT_W-3:0] margin_raw;
  logic [dwr_pkg::HEIGHT_W-3:0] margin;
  logic [dwr_pkg::Y_W-1:0]      y_high;
  logic [dwr_pkg::Y_W-1:0]      y_low_raw;
  logic [dwr_pkg::Y_W-1:0]      y_low;
  logic                         low_clamp;

  assign margin_raw = area_height[dwr_pkg::HEIGHT_W-1:2];
  assign margin     = (margin_raw == '0) ? (dwr_pkg::HEIGHT_W-2)'(1) : margin_raw;
  assign y_high     = {1'b0, top_y} + {3'b0, margin};
  assign low_clamp  = ({1'b0, area_height} < ({2'b0, margin, 1'b0} + 9'd1));
  assign y_low_raw  = {1'b0, top_y} + {1'b0, area_height} - 9'd1 - {3'b0, margin};
  assign y_low      = low_clamp ? y_high : y_low_raw;

  // Sample store
  logic                         mem [dwr_pkg::SAMPLE_DEPTH];
  logic [dwr_pkg::IDX_W-1:0]    rd_addr;
  logic                         rd_data;

  // Control
  dwr_pkg::dwr_state_t state, state_next;
  logic                        accept;
  logic                        draw_go;
  logic                        count_zero;
  logic                        out_free;
  logic                        div_start;
  logic                        div_done;
  logic [dwr_pkg::PROD_W-1:0]  quotient;
  logic [dwr_pkg::COL_W-1:0]   col;
  logic                        level;
  logic                        prev_level;
  logic                        need_edge;
  logic                        emit_edge;
  logic                        emit_point;
  logic [dwr_pkg::COUNT_W-1:0] idx_clamp;
  logic [dwr_pkg::COUNT_W-1:0] count_m1;

  assign accept     = in_valid && !in_stall;
  assign draw_go    = accept && (cmd == dwr_pkg::CMD_DRAW) &&
                      (area_width != '0) && (area_height != '0);
  assign count_zero = (sample_count == '0);
  assign out_free   = !out_valid || !out_stall;
  assign need_edge  = (col != '0) && (rd_data != prev_level);
  assign count_m1   = sample_count - 1'b1;
  assign idx_clamp  = (quotient >= {{(dwr_pkg::PROD_W - dwr_pkg::COUNT_W){1'b0}},
                                    sample_count}) ?
                      count_m1 : quotient[dwr_pkg::COUNT_W-1:0];

  dwr_muldiv u_muldiv (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .col      (col),
    .count    (sample_count),
    .width    (area_width),
    .done     (div_done),
    .quotient (quotient)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      dwr_pkg::ST_IDLE:
        if (draw_go) state_next = count_zero ? dwr_pkg::ST_POINT : dwr_pkg::ST_CALC;
      dwr_pkg::ST_CALC:
        if (div_done) state_next = dwr_pkg::ST_READ;
      dwr_pkg::ST_READ:
        state_next = dwr_pkg::ST_EDGE;
      dwr_pkg::ST_EDGE:
        if (!need_edge || out_free) state_next = dwr_pkg::ST_POINT;
      dwr_pkg::ST_POINT:
        if (out_free) state_next = dwr_pkg::ST_IDLE;
      default:
        state_next = dwr_pkg::ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    in_stall   = 1'b1;
    div_start  = 1'b0;
    emit_edge  = 1'b0;
    emit_point = 1'b0;
    case (state)
      dwr_pkg::ST_IDLE:  in_stall   = 1'b0;
      dwr_pkg::ST_CALC:  div_start  = 1'b1;
      dwr_pkg::ST_EDGE:  emit_edge  = need_edge && out_free;
      dwr_pkg::ST_POINT: emit_point = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= dwr_pkg::ST_IDLE;
      prev_level <= 1'b0;
    end else begin
      state <= state_next;
      if (emit_point) prev_level <= level;
    end
  end

  // Capture column, level and read address
  always_ff @(posedge clk) begin
    if (draw_go) begin
      col   <= column;
      level <= 1'b0;
    end
    if (div_done) begin
      rd_addr <= idx_clamp[dwr_pkg::COUNT_W-1] ? '1 : idx_clamp[dwr_pkg::IDX_W-1:0];
    end
    if (state == dwr_pkg::ST_EDGE) level <= rd_data;
  end

  // Store write on load, registered read
  always_ff @(posedge clk) begin
    if (accept && (cmd == dwr_pkg::CMD_LOAD)) mem[sample_index] <= sample_bit;
    rd_data <= mem[rd_addr];
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_edge || emit_point) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_edge) begin
      seg_x      <= {1'b0, left_x} + {1'b0, col};
      seg_y_from <= y_high;
      seg_y_to   <= y_low;
      seg_color  <= line_color;
      is_edge    <= 1'b1;
      last       <= 1'b0;
    end else if (emit_point) begin
      seg_x      <= {1'b0, left_x} + {1'b0, col};
      seg_y_from <= level ? y_high : y_low;
      seg_y_to   <= level ? y_high : y_low;
      seg_color  <= line_color;
      is_edge    <= 1'b0;
      last       <= 1'b1;
    end
  end

endmodule
`default_nettype wire

/* rtl/dwr_muldiv.sv */
`default_nettype none
// Bit-serial column*count/width: shift-add multiply, then restoring divide.
module dwr_muldiv (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic [dwr_pkg::COL_W-1:0]    col,
  input  wire logic [dwr_pkg::COUNT_W-1:0]  count,
  input  wire logic [dwr_pkg::WIDTH_W-1:0]  width,
  output logic                              done,
  output logic [dwr_pkg::PROD_W-1:0]        quotient
);

  dwr_pkg::md_state_t state, state_next;
  logic [dwr_pkg::CNT_W-1:0]   cnt;
  logic [dwr_pkg::COL_W-1:0]   mplr;
  logic [dwr_pkg::PROD_W-1:0]  acc;
  logic [dwr_pkg::WIDTH_W-1:0] rem;
  logic                        mul_last;
  logic                        div_last;
  logic [dwr_pkg::WIDTH_W:0]   trial;
  logic                        q_bit;
  logic [dwr_pkg::PROD_W-1:0]  addend;

  assign mul_last = (cnt == dwr_pkg::CNT_W'(dwr_pkg::COL_W - 1));
  assign div_last = (cnt == dwr_pkg::CNT_W'(dwr_pkg::PROD_W - 1));
  assign trial    = {rem, acc[dwr_pkg::PROD_W-1]};
  assign q_bit    = (trial >= {1'b0, width});
  assign addend   = mplr[dwr_pkg::COL_W-1] ?
                    {{(dwr_pkg::PROD_W - dwr_pkg::COUNT_W){1'b0}}, count} : '0;
  // Include the quotient bit settled in the current step; complete with done
  assign quotient = {acc[dwr_pkg::PROD_W-2:0], q_bit};

  // Next phase
  always_comb begin
    state_next = state;
    case (state)
      dwr_pkg::MD_IDLE: if (start) state_next = dwr_pkg::MD_MUL;
      dwr_pkg::MD_MUL:  if (mul_last) state_next = dwr_pkg::MD_DIV;
      dwr_pkg::MD_DIV:  if (div_last) state_next = dwr_pkg::MD_IDLE;
      default:          state_next = dwr_pkg::MD_IDLE;
    endcase
  end

  // Done strobe on the last divide step
  always_comb begin
    case (state)
      dwr_pkg::MD_DIV: done = div_last;
      default:         done = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dwr_pkg::MD_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath: one multiplier bit or one quotient bit per cycle
  always_ff @(posedge clk) begin
    case (state)
      dwr_pkg::MD_IDLE: begin
        cnt  <= '0;
        mplr <= col;
        acc  <= '0;
        rem  <= '0;
      end
      dwr_pkg::MD_MUL: begin
        acc  <= {acc[dwr_pkg::PROD_W-2:0], 1'b0} + addend;
        mplr <= {mplr[dwr_pkg::COL_W-2:0], 1'b0};
        cnt  <= mul_last ? '0 : cnt + 1'b1;
      end
      dwr_pkg::MD_DIV: begin
        rem <= q_bit ? dwr_pkg::WIDTH_W'(trial - {1'b0, width})
                     : trial[dwr_pkg::WIDTH_W-1:0];
        acc <= {acc[dwr_pkg::PROD_W-2:0], q_bit};
        cnt <= cnt + 1'b1;
      end
      default: begin
        cnt <= '0;
      end
    endcase
  end

endmodule
`default_nettype wire
